@@ rtl/tccw_pkg.sv @@
// shared types and constants of the text console cell writer
`default_nettype none

package tccw_pkg;

    // default store geometry
    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 64;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int MODE_W     = 2;
    localparam int POS_W      = 14;
    localparam int COLUMNS_W  = 8;
    localparam int ROWS_W     = 7;
    localparam int CELL_W     = ATTR_W + CHAR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR    = 2'd2;

    // configuration reset values
    localparam logic [COLUMNS_W-1:0] RST_COLUMNS = 8'd80;
    localparam logic [ROWS_W-1:0]    RST_ROWS    = 7'd25;
    localparam logic [ATTR_W-1:0]    RST_ATTR    = 8'h07;
    localparam logic [CELL_W-1:0]    RST_CELL    = 16'h0700;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_SEEK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // seek modes
    localparam logic [MODE_W-1:0] SEEK_ABS     = 2'd0;
    localparam logic [MODE_W-1:0] SEEK_FWD     = 2'd1;
    localparam logic [MODE_W-1:0] SEEK_END     = 2'd2;
    localparam logic [MODE_W-1:0] SEEK_FWD_ALT = 2'd3;

    // special characters
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified command kinds
    typedef enum logic [2:0] {
        K_PUT,
        K_NEWLINE,
        K_BACKSPACE,
        K_SEEK_ABS,
        K_SEEK_FWD,
        K_SEEK_END,
        K_CLEAR,
        K_READ
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
    } t_cmd;

    typedef struct packed {
        logic [POS_W-1:0]  cursor;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attribute;
        logic              scrolled;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/tccw_front.sv @@
// front stage: accepts and classifies commands
`default_nettype none

module tccw_front import tccw_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_operation,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic [MODE_W-1:0] i_seek_mode,
    input  wire logic [POS_W-1:0]  i_position,
    input  wire logic              i_init,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output t_cmd                   o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    // hold off while the stage is stuck or the store is being initialized
    assign busy   = i_init | (r_valid & i_q_full);
    assign accept = start & ~busy;
    assign o_push = r_valid & ~i_q_full;
    assign o_cmd  = r_cmd;

    // classify the incoming transaction
    always_comb begin
        n_cmd.ch  = i_char_code;
        n_cmd.pos = i_position;
        unique case (i_operation)
            OP_PUT: begin
                if (i_char_code == CH_NEWLINE) begin
                    n_cmd.kind = K_NEWLINE;
                end else if (i_char_code == CH_BACKSPACE) begin
                    n_cmd.kind = K_BACKSPACE;
                end else begin
                    n_cmd.kind = K_PUT;
                end
            end
            OP_SEEK: begin
                unique case (i_seek_mode) inside
                    SEEK_FWD, SEEK_FWD_ALT: n_cmd.kind = K_SEEK_FWD;
                    SEEK_END:               n_cmd.kind = K_SEEK_END;
                    default:                n_cmd.kind = K_SEEK_ABS;
                endcase
            end
            OP_CLEAR: n_cmd.kind = K_CLEAR;
            default:  n_cmd.kind = K_READ;
        endcase
    end

    // holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tccw_queue.sv @@
// short command queue between front and back
`default_nettype none

module tccw_queue import tccw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    input  wire logic i_pop,
    output logic      o_valid,
    output logic      o_full,
    output t_cmd      o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tccw_div.sv @@
// restoring divider that yields the remainder, one bit per cycle
`default_nettype none

module tccw_div #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [DEN_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // shift in the next dividend bit and try a subtract
    assign trial  = {r_rem, r_num[NUM_W-1]};
    assign diff   = trial - {1'b0, r_den};
    assign o_done = r_done;
    assign o_rem  = r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= (trial >= {1'b0, r_den}) ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/tccw_back.sv @@
// back end: executes commands on the cell store and produces results
`default_nettype none

module tccw_back import tccw_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [COLUMNS_W-1:0] i_columns,
    input  wire logic [ROWS_W-1:0]    i_rows,
    input  wire logic [ATTR_W-1:0]    i_text_attribute,
    input  wire logic                 i_q_valid,
    input  t_cmd                      i_q_cmd,
    output logic                      o_q_pop,
    output logic                      o_init,
    output logic                      o_res_valid,
    output t_result                   o_result
);

    localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int SIZE_W      = $clog2(STORE_CELLS + 1);
    localparam int CUR_W       = SIZE_W + 1;
    localparam int COL_W       = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W       = $clog2(MAX_ROWS + 1);
    localparam int SUM_W       = ((CUR_W > POS_W) ? CUR_W : POS_W) + 1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_BACK,
        S_NL_START,
        S_NL_WAIT,
        S_NL_CHECK,
        S_SEEK,
        S_CLEAR,
        S_READ,
        S_READ_DATA,
        S_SCR_COPY,
        S_SCR_BLANK
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    logic [CUR_W-1:0]  r_cursor;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_cp_addr;
    logic              r_cp_valid;
    logic              r_put_pend;
    logic              r_emit;
    logic              r_hit;
    logic              r_scrolled;
    logic [CHAR_W-1:0] r_rd_char;
    logic [ATTR_W-1:0] r_rd_attr;
    logic              r_res_valid;
    t_result           r_result;

    // screen geometry from configuration
    logic [COL_W-1:0]  col_used;
    logic [ROW_W-1:0]  row_used;
    logic [COL_W-1:0]  r_cols;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_last;
    logic [CUR_W-1:0]  size_c;

    // cell store
    logic [CELL_W-1:0] r_cells [STORE_CELLS];
    logic [CELL_W-1:0] r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;

    // divider for newline
    logic              div_start;
    logic              div_done;
    logic [COL_W-1:0]  div_rem;

    // seek target
    logic [SUM_W-1:0]  pos_x;
    logic [SUM_W-1:0]  cur_x;
    logic [SUM_W-1:0]  size_x;
    logic [SUM_W-1:0]  tgt;

    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;
    assign o_init      = (r_state == S_INIT);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;
    assign size_c      = CUR_W'(r_size);
    assign div_start   = (r_state == S_NL_START);

    // clamp configuration to the supported geometry
    always_comb begin
        if (i_columns == '0) begin
            col_used = COL_W'(1);
        end else if (int'(i_columns) > MAX_COLUMNS) begin
            col_used = COL_W'(MAX_COLUMNS);
        end else begin
            col_used = COL_W'(i_columns);
        end
        if (i_rows == '0) begin
            row_used = ROW_W'(1);
        end else if (int'(i_rows) > MAX_ROWS) begin
            row_used = ROW_W'(MAX_ROWS);
        end else begin
            row_used = ROW_W'(i_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cols <= col_used;
        r_size <= SIZE_W'(col_used) * SIZE_W'(row_used);
        r_last <= r_size - SIZE_W'(r_cols);
    end

    // seek target with saturation to the screen size
    always_comb begin
        pos_x  = SUM_W'(r_cmd.pos);
        cur_x  = SUM_W'(r_cursor);
        size_x = SUM_W'(r_size);
        case (r_cmd.kind)
            K_SEEK_FWD: tgt = cur_x + pos_x;
            K_SEEK_END: tgt = (pos_x > size_x) ? '0 : size_x - pos_x;
            default:    tgt = pos_x;
        endcase
        if (tgt > size_x) begin
            tgt = size_x;
        end
    end

    // store port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = {i_text_attribute, CH_NUL};
        mem_raddr = ADDR_W'(SIZE_W'(r_idx) + SIZE_W'(r_cols));
        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = RST_CELL;
            end
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_PUT: begin
                mem_we    = (r_cursor < size_c);
                mem_waddr = ADDR_W'(r_cursor);
                mem_wdata = {i_text_attribute, r_cmd.ch};
            end
            S_BACK: begin
                mem_we    = (r_cursor != '0);
                mem_waddr = ADDR_W'(r_cursor - CUR_W'(1));
                mem_wdata = {i_text_attribute, CH_SPACE};
            end
            S_SCR_COPY: begin
                mem_we    = r_cp_valid;
                mem_waddr = r_cp_addr;
                mem_wdata = r_rd_data;
            end
            S_SCR_BLANK: begin
                mem_we = 1'b1;
            end
            S_READ: begin
                mem_raddr = ADDR_W'(r_cmd.pos);
            end
            default: begin
            end
        endcase
    end

    // cell store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_cells[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_cells[mem_raddr];
    end

    tccw_div #(
        .NUM_W (SIZE_W),
        .DEN_W (COL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (SIZE_W'(r_cursor)),
        .i_den   (r_cols),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // command sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_idx       <= '0;
            r_cursor    <= '0;
            r_emit      <= 1'b0;
            r_res_valid <= 1'b0;
            r_cp_valid  <= 1'b0;
            r_put_pend  <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                // power-up pass over the whole store
                S_INIT: begin
                    if (r_idx == ADDR_W'(STORE_CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                // present the finished result and take the next command
                S_IDLE: begin
                    if (r_emit) begin
                        r_res_valid                <= 1'b1;
                        r_result.cursor            <= POS_W'(r_cursor);
                        r_result.cell_char         <= r_rd_char;
                        r_result.cell_attribute    <= r_rd_attr;
                        r_result.scrolled          <= r_scrolled;
                        r_emit                     <= 1'b0;
                    end
                    if (i_q_valid) begin
                        r_cmd      <= i_q_cmd;
                        r_scrolled <= 1'b0;
                        r_rd_char  <= '0;
                        r_rd_attr  <= '0;
                        r_put_pend <= 1'b0;
                        r_idx      <= '0;
                        if (r_cursor > size_c) begin
                            r_cursor <= size_c;
                        end
                        case (i_q_cmd.kind)
                            K_PUT:       r_state <= S_PUT;
                            K_NEWLINE:   r_state <= S_NL_START;
                            K_BACKSPACE: r_state <= S_BACK;
                            K_CLEAR:     r_state <= S_CLEAR;
                            K_READ:      r_state <= S_READ;
                            default:     r_state <= S_SEEK;
                        endcase
                    end
                end
                // ordinary character, scrolling first when already at the end and afterwards when the write reaches it
                S_PUT: begin
                    if (r_cursor >= size_c) begin
                        r_put_pend <= 1'b1;
                        r_idx      <= '0;
                        r_cp_valid <= 1'b0;
                        r_state    <= S_SCR_COPY;
                    end else begin
                        r_put_pend <= 1'b0;
                        r_cursor   <= r_cursor + CUR_W'(1);
                        if ((r_cursor + CUR_W'(1)) >= size_c) begin
                            r_idx      <= '0;
                            r_cp_valid <= 1'b0;
                            r_state    <= S_SCR_COPY;
                        end else begin
                            r_emit  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                // backspace: step back and blank
                S_BACK: begin
                    if (r_cursor != '0) begin
                        r_cursor <= r_cursor - CUR_W'(1);
                    end
                    r_emit  <= 1'b1;
                    r_state <= S_IDLE;
                end
                // newline: find the column, then go to the next row start, scrolling when past the end
                S_NL_START: begin
                    r_state <= S_NL_WAIT;
                end
                S_NL_WAIT: begin
                    if (div_done) begin
                        r_cursor <= r_cursor - CUR_W'(div_rem) + CUR_W'(r_cols);
                        r_state  <= S_NL_CHECK;
                    end
                end
                S_NL_CHECK: begin
                    if (r_cursor >= size_c) begin
                        r_idx      <= '0;
                        r_cp_valid <= 1'b0;
                        r_state    <= S_SCR_COPY;
                    end else begin
                        r_emit  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_SEEK: begin
                    r_cursor <= CUR_W'(tgt);
                    r_emit   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                // clear sweep over every cell
                S_CLEAR: begin
                    if (r_idx == ADDR_W'(STORE_CELLS - 1)) begin
                        r_cursor <= '0;
                        r_emit   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_READ: begin
                    r_hit   <= (SUM_W'(r_cmd.pos) < SUM_W'(r_size));
                    r_state <= S_READ_DATA;
                end
                S_READ_DATA: begin
                    if (r_hit) begin
                        r_rd_char <= r_rd_data[CHAR_W-1:0];
                        r_rd_attr <= r_rd_data[CELL_W-1:CHAR_W];
                    end
                    r_emit  <= 1'b1;
                    r_state <= S_IDLE;
                end
                // scroll: copy each cell one row up, reading each source cell in the cycle before its write
                S_SCR_COPY: begin
                    if (SIZE_W'(r_idx) < r_last) begin
                        r_cp_valid <= 1'b1;
                        r_cp_addr  <= r_idx;
                        r_idx      <= r_idx + 1'b1;
                    end else begin
                        r_cp_valid <= 1'b0;
                        r_state    <= S_SCR_BLANK;
                    end
                end
                // scroll: blank the last row
                S_SCR_BLANK: begin
                    if (SIZE_W'(r_idx) == (r_size - SIZE_W'(1))) begin
                        r_cursor   <= CUR_W'(r_last);
                        r_scrolled <= 1'b1;
                        if (r_put_pend) begin
                            r_state <= S_PUT;
                        end else begin
                            r_emit  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/text_console_cell_writer_unit.sv @@
// top level of the text console cell writer
// an accepted command is registered in the front stage, waits in the queue and is then executed
// by the back end sequencer, which registers its result; a newline adds a remainder division by the column
// count, a scroll a copy of each visible cell one row up, a clear a sweep over every store cell (8192 by default)
// the back end takes a new command only once the last is done; front and queue keep accepting until full
// synchronous reset, then busy for one pass over the store; results cannot be stalled
`default_nettype none

module text_console_cell_writer_unit import tccw_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic [MODE_W-1:0]     i_seek_mode,
    input  wire logic [POS_W-1:0]      i_position,
    output logic                       o_strobe,
    output logic [POS_W-1:0]           o_cursor,
    output logic [CHAR_W-1:0]          o_cell_char,
    output logic [ATTR_W-1:0]          o_cell_attribute,
    output logic                       o_scrolled,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [COLUMNS_W-1:0] r_columns;
    logic [ROWS_W-1:0]    r_rows;
    logic [ATTR_W-1:0]    r_attr;

    logic    init;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    push;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_result result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= RST_COLUMNS;
            r_rows    <= RST_ROWS;
            r_attr    <= RST_ATTR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COLUMNS: r_columns <= i_cfg_wdata[COLUMNS_W-1:0];
                CFG_ROWS:    r_rows    <= i_cfg_wdata[ROWS_W-1:0];
                CFG_ATTR:    r_attr    <= i_cfg_wdata[ATTR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    tccw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_char_code (i_char_code),
        .i_seek_mode (i_seek_mode),
        .i_position  (i_position),
        .i_init      (init),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    tccw_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_columns        (r_columns),
        .i_rows           (r_rows),
        .i_text_attribute (r_attr),
        .i_q_valid        (q_valid),
        .i_q_cmd          (head_cmd),
        .o_q_pop          (q_pop),
        .o_init           (init),
        .o_res_valid      (o_strobe),
        .o_result         (result)
    );

    // result transaction ports
    assign o_cursor         = result.cursor;
    assign o_cell_char      = result.cell_char;
    assign o_cell_attribute = result.cell_attribute;
    assign o_scrolled       = result.scrolled;

endmodule

`default_nettype wire
